@@ sv/bhte_pkg.sv @@
// ============================================================================
// bhte_pkg: shared definitions of the bucketed hash table engine
// Field widths, request and result codes, digest constants and the
// control group that the sequencer hands to the table store.
// ============================================================================
package bhte_pkg;

  // Default geometry of the table.
  localparam int unsigned NUM_BUCKETS_DEF = 256;
  localparam int unsigned WAYS_DEF        = 4;

  // Field widths.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 11;

  // Digest: the shift amount is the key modulo 32, and the shifted key
  // is shifted on by a fixed ten places.
  localparam int unsigned SHIFT_SEL_W    = 5;
  localparam int unsigned HASH_PRE_SHIFT = 10;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd5;

  // Enables of the table store ports.
  typedef struct packed {
    logic row_re;
    logic row_we;
    logic kv_re;
    logic key_we;
    logic val_we;
  } store_ctl_t;

endpackage

@@ sv/bhte_digest.sv @@
// ============================================================================
// bhte_digest: bucket selection unit
// Computes the shift-and-xor digest of a key and reduces it modulo the
// bucket count: a mask for a power of two, else one reciprocal multiply per 16-bit chunk.
// ============================================================================
module bhte_digest import bhte_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF,
  localparam int unsigned BucketW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [KEY_W-1:0]   key_i,
  output logic               done_o,
  output logic [BucketW-1:0] bucket_o
);

  // The digest is reduced most significant chunk first. A bucket count of at
  // most 65536 keeps every partial remainder inside one chunk, so the
  // running word stays below the bucket count times two to the chunk width.
  localparam bit          IsPow2    = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  localparam int unsigned ChunkW    = 16;
  localparam int unsigned WordW     = 2 * ChunkW;
  localparam int unsigned ProdW     = 2 * WordW;
  localparam int unsigned NumChunks = KEY_W / ChunkW;
  localparam int unsigned CntW      = $clog2(NumChunks);
  localparam int unsigned RemW      = BucketW + 1;
  // Floor of two to the word width over the bucket count.
  localparam logic [WordW-1:0] Recip = WordW'((64'd1 << WordW) / 64'(NUM_BUCKETS));

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_XOR  = 3'd1;
  localparam logic [2:0] D_MUL  = 3'd2;
  localparam logic [2:0] D_SUB  = 3'd3;
  localparam logic [2:0] D_FIX  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q;
  logic [KEY_W-1:0]       dig_q;
  logic [SHIFT_SEL_W-1:0] sft_q;
  logic [WordW-1:0]       x_q;
  logic [ChunkW-1:0]      quo_q;
  logic [RemW-1:0]        rem_q;
  logic [KEY_W-1:0]       dig_mix;
  logic [ProdW-1:0]       prod;
  logic [WordW-1:0]       quo_mul;
  logic [WordW-1:0]       diff;
  logic [RemW-1:0]        rem_fix;

  // Xor of the shifted key with itself shifted down by twice the amount.
  assign dig_mix = dig_q ^ (dig_q >> {sft_q, 1'b0});

  // Quotient estimate by the reciprocal; it is short by at most one, so the
  // remainder needs at most one final subtraction.
  assign prod    = ProdW'(x_q) * ProdW'(Recip);
  assign quo_mul = WordW'(quo_q) * WordW'(NUM_BUCKETS);
  assign diff    = x_q - quo_mul;
  assign rem_fix = (rem_q >= RemW'(NUM_BUCKETS)) ? (rem_q - RemW'(NUM_BUCKETS)) : rem_q;

  // Sequencer of the unit.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      D_IDLE: begin
        if (start_i) state_d = D_XOR;
      end
      D_XOR: begin
        if (IsPow2) begin
          state_d = D_IDLE;
          done_d  = 1'b1;
        end else begin
          state_d = D_MUL;
        end
      end
      D_MUL: begin
        state_d = D_SUB;
      end
      D_SUB: begin
        state_d = D_FIX;
      end
      D_FIX: begin
        if (cnt_q == CntW'(NumChunks - 1)) begin
          state_d = D_IDLE;
          done_d  = 1'b1;
        end else begin
          state_d = D_MUL;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (state_q == D_XOR) begin
        cnt_q <= '0;
      end else if (state_q == D_FIX) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Digest and remainder datapath.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          dig_q <= (key_i << key_i[SHIFT_SEL_W-1:0]) << HASH_PRE_SHIFT;
          sft_q <= key_i[SHIFT_SEL_W-1:0];
        end
      end
      D_XOR: begin
        // The low bits already give the bucket when the count is a power of two.
        dig_q <= dig_mix << ChunkW;
        x_q   <= WordW'(dig_mix[KEY_W-1 -: ChunkW]);
        rem_q <= RemW'(dig_mix[BucketW-1:0] & BucketW'(NUM_BUCKETS - 1));
      end
      D_MUL: begin
        quo_q <= prod[WordW +: ChunkW];
      end
      D_SUB: begin
        rem_q <= diff[RemW-1:0];
      end
      D_FIX: begin
        rem_q <= rem_fix;
        x_q   <= {ChunkW'(rem_fix), dig_q[KEY_W-1 -: ChunkW]};
        dig_q <= dig_q << ChunkW;
      end
      default: begin
      end
    endcase
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q[BucketW-1:0];

endmodule

@@ sv/bhte_store.sv @@
// ============================================================================
// bhte_store: table storage
// Valid marks kept as one row of way bits per bucket, plus key and value
// memories of one entry per way, all with registered read data.
// ============================================================================
module bhte_store import bhte_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int unsigned WAYS        = WAYS_DEF,
  localparam int unsigned Slots   = NUM_BUCKETS * WAYS,
  localparam int unsigned BucketW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
  localparam int unsigned SlotW   = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic               clk_i,
  input  store_ctl_t         ctl_i,
  input  logic [BucketW-1:0] row_addr_i,
  input  logic [WAYS-1:0]    row_wdata_i,
  output logic [WAYS-1:0]    row_rdata_o,
  input  logic [SlotW-1:0]   kv_raddr_i,
  input  logic [SlotW-1:0]   kv_waddr_i,
  input  logic [KEY_W-1:0]   key_wdata_i,
  input  logic [VAL_W-1:0]   val_wdata_i,
  output logic [KEY_W-1:0]   key_rdata_o,
  output logic [VAL_W-1:0]   val_rdata_o
);

  logic [WAYS-1:0]  row_mem [NUM_BUCKETS];
  logic [KEY_W-1:0] key_mem [Slots];
  logic [VAL_W-1:0] val_mem [Slots];

  logic [WAYS-1:0]  row_rdata_q;
  logic [KEY_W-1:0] key_rdata_q;
  logic [VAL_W-1:0] val_rdata_q;

  // Valid rows: one port shared by reads and writes.
  always_ff @(posedge clk_i) begin
    if (ctl_i.row_we) row_mem[row_addr_i] <= row_wdata_i;
    if (ctl_i.row_re) row_rdata_q <= row_mem[row_addr_i];
  end

  // Key and value entries: one read port and one write port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.key_we) key_mem[kv_waddr_i] <= key_wdata_i;
    if (ctl_i.kv_re)  key_rdata_q <= key_mem[kv_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.val_we) val_mem[kv_waddr_i] <= val_wdata_i;
    if (ctl_i.kv_re)  val_rdata_q <= val_mem[kv_raddr_i];
  end

  assign row_rdata_o = row_rdata_q;
  assign key_rdata_o = key_rdata_q;
  assign val_rdata_o = val_rdata_q;

endmodule

@@ sv/bucketed_hash_table_engine_top.sv @@
// ============================================================================
// bucketed_hash_table_engine_top: four-way bucketed key/value hash table
// Lookup, insert or update, and remove of 64-bit keys with 64-bit values,
// one request at a time under a small sequencer.
// ============================================================================
// Flow: an accepted item passes the digest unit (S_HASH, longer when the bucket
// count is not a power of two), the row and first key read (S_LOOK), a scan of
// the ways that stops at a hit or the last way (S_SCAN) and the result write
// (S_ACT), which waits while a held result is not taken. Only one item is in
// flight: the next is accepted once the last has left S_ACT. The result register frees the input side.
// Reset: a clearing pass wipes the valid row of every bucket, and no
// item is accepted until it ends.
module bucketed_hash_table_engine_top import bhte_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int unsigned WAYS        = WAYS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // key [63:0], value [127:64]
  input  logic [1:0]   s_axis_tuser,   // mode [1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,   // found_value [63:0], entry_count [74:64], zero
  output logic [2:0]   m_axis_tuser    // status [2:0]
);

  localparam int unsigned Slots   = NUM_BUCKETS * WAYS;
  localparam int unsigned BucketW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned SlotW   = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned WayW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned OccW    = $clog2(Slots + 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_LOOK = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_ACT  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [BucketW-1:0]  clr_q;
  logic [WayW-1:0]     way_q;
  logic                hit_q;
  logic                emp_found_q;
  logic [OccW-1:0]     occ_q, occ_d;
  logic                out_valid_q;

  logic [MODE_W-1:0]   mode_q;
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    val_q;
  logic [BucketW-1:0]  bucket_q;
  logic [SlotW-1:0]    base_q;
  logic [WayW-1:0]     hit_way_q;
  logic [WayW-1:0]     emp_way_q;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [VAL_W-1:0]    out_found_q, out_found_d;
  logic [COUNT_W-1:0]  out_count_q;

  logic                in_accept;
  logic                dig_done;
  logic [BucketW-1:0]  dig_bucket;
  store_ctl_t          st_ctl;
  logic [BucketW-1:0]  row_addr;
  logic [WAYS-1:0]     row_wdata;
  logic [WAYS-1:0]     row_rdata;
  logic [SlotW-1:0]    kv_raddr;
  logic [SlotW-1:0]    kv_waddr;
  logic [KEY_W-1:0]    key_rdata;
  logic [VAL_W-1:0]    val_rdata;
  logic [WayW-1:0]     rd_way;
  logic [WayW-1:0]     wr_way;
  logic [WAYS-1:0]     way_bit;
  logic                way_hit;
  logic                last_way;
  logic                out_free;
  logic                act_go;
  logic                do_upd;
  logic                do_ins;
  logic                do_rem;
  logic [OccW+COUNT_W-1:0] occ_ext;

  // Handshake.
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign act_go        = (state_q == S_ACT) && out_free;

  // Bucket selection.
  bhte_digest #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_digest (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .key_i   (s_axis_tdata[KEY_W-1:0]),
    .done_o  (dig_done),
    .bucket_o(dig_bucket)
  );

  // Way compare: one way per cycle through a single key comparator.
  assign way_hit  = row_rdata[way_q] && (key_rdata == key_q);
  assign last_way = (way_q == WayW'(WAYS - 1));

  // Action decode.
  assign do_upd  = (mode_q == MODE_INSERT) && hit_q;
  assign do_ins  = (mode_q == MODE_INSERT) && !hit_q && emp_found_q;
  assign do_rem  = (mode_q == MODE_REMOVE) && hit_q;
  assign wr_way  = hit_q ? hit_way_q : emp_way_q;
  assign way_bit = WAYS'(1) << wr_way;

  // Store port control.
  assign rd_way    = (state_q == S_LOOK) ? '0 : WayW'(way_q + 1'b1);
  assign kv_raddr  = base_q + SlotW'(rd_way);
  assign kv_waddr  = base_q + SlotW'(wr_way);
  assign row_addr  = (state_q == S_CLR) ? clr_q : bucket_q;

  always_comb begin
    if (state_q == S_CLR) begin
      row_wdata = '0;
    end else if (do_rem) begin
      row_wdata = row_rdata & ~way_bit;
    end else begin
      row_wdata = row_rdata | way_bit;
    end
  end

  always_comb begin
    st_ctl.row_re = (state_q == S_LOOK);
    st_ctl.row_we = (state_q == S_CLR) || (act_go && (do_ins || do_rem));
    st_ctl.kv_re  = (state_q == S_LOOK) ||
                    ((state_q == S_SCAN) && !way_hit && !last_way);
    st_ctl.key_we = act_go && do_ins;
    st_ctl.val_we = act_go && (do_ins || do_upd);
  end

  bhte_store #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .WAYS       (WAYS)
  ) u_store (
    .clk_i      (clk_i),
    .ctl_i      (st_ctl),
    .row_addr_i (row_addr),
    .row_wdata_i(row_wdata),
    .row_rdata_o(row_rdata),
    .kv_raddr_i (kv_raddr),
    .kv_waddr_i (kv_waddr),
    .key_wdata_i(key_q),
    .val_wdata_i(val_q),
    .key_rdata_o(key_rdata),
    .val_rdata_o(val_rdata)
  );

  // Result of the request and the new entry count.
  always_comb begin
    out_status_d = STATUS_NOT_FOUND;
    out_found_d  = '0;
    unique case (mode_q)
      MODE_LOOKUP: begin
        if (hit_q) begin
          out_status_d = STATUS_FOUND;
          out_found_d  = val_rdata;
        end
      end
      MODE_INSERT: begin
        if (hit_q) begin
          out_status_d = STATUS_UPDATED;
        end else if (emp_found_q) begin
          out_status_d = STATUS_INSERTED;
        end else begin
          out_status_d = STATUS_FULL;
        end
      end
      MODE_REMOVE: begin
        if (hit_q) out_status_d = STATUS_REMOVED;
      end
      default: out_status_d = STATUS_NOT_FOUND;
    endcase
  end

  always_comb begin
    occ_d = occ_q;
    if (do_ins) begin
      occ_d = occ_q + 1'b1;
    end else if (do_rem) begin
      occ_d = occ_q - 1'b1;
    end
  end

  assign occ_ext = {COUNT_W'(0), occ_d};

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR: begin
        if (clr_q == BucketW'(NUM_BUCKETS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_accept) state_d = S_HASH;
      end
      S_HASH: begin
        if (dig_done) state_d = S_LOOK;
      end
      S_LOOK: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (way_hit || last_way) state_d = S_ACT;
      end
      S_ACT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      way_q       <= '0;
      hit_q       <= 1'b0;
      emp_found_q <= 1'b0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (state_q == S_LOOK) begin
        way_q       <= '0;
        hit_q       <= 1'b0;
        emp_found_q <= 1'b0;
      end
      if (state_q == S_SCAN) begin
        if (way_hit) begin
          hit_q <= 1'b1;
        end else begin
          if (!row_rdata[way_q]) emp_found_q <= 1'b1;
          if (!last_way) way_q <= way_q + 1'b1;
        end
      end
      if (act_go) begin
        occ_q       <= occ_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, scan and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= s_axis_tuser;
      key_q  <= s_axis_tdata[KEY_W-1:0];
      val_q  <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if ((state_q == S_HASH) && dig_done) begin
      bucket_q <= dig_bucket;
      base_q   <= SlotW'(dig_bucket) * SlotW'(WAYS);
    end
    if (state_q == S_SCAN) begin
      if (way_hit) hit_way_q <= way_q;
      if (!way_hit && !row_rdata[way_q] && !emp_found_q) emp_way_q <= way_q;
    end
    if (act_go) begin
      out_status_q <= out_status_d;
      out_found_q  <= out_found_d;
      out_count_q  <= occ_ext[COUNT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {5'd0, out_count_q, out_found_q};

endmodule
